// ===== src/mlr_pkg.sv =====
package mlr_pkg;

	// Default coordinate width and the headroom the decision term needs above it.
	localparam int COORD_BITS_DEFAULT = 12;
	localparam int DEC_EXTRA_BITS = 4;

	// Operation codes carried on the input tuser.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// Bit 0 set means the axes are swapped; bit 1 set means the minor axis falls.
	typedef enum logic [1:0] {
		SLOPE_SHALLOW_POS = 2'd0,
		SLOPE_STEEP_POS   = 2'd1,
		SLOPE_SHALLOW_NEG = 2'd2,
		SLOPE_STEEP_NEG   = 2'd3
	} slope_t;

endpackage

// ===== src/mlr_setup.sv =====
module mlr_setup #(
	parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEFAULT
) (
	input  logic [COORD_BITS-1:0] x_first,
	input  logic [COORD_BITS-1:0] y_first,
	input  logic [COORD_BITS-1:0] x_second,
	input  logic [COORD_BITS-1:0] y_second,
	output logic [COORD_BITS-1:0] walk_major,
	output logic [COORD_BITS-1:0] walk_minor,
	output logic [COORD_BITS-1:0] stop_major,
	output logic [COORD_BITS-1:0] span_major,
	output logic [COORD_BITS-1:0] span_minor,
	output logic signed [COORD_BITS+mlr_pkg::DEC_EXTRA_BITS-1:0] decision,
	output mlr_pkg::slope_t slope_case
);
	import mlr_pkg::*;

	localparam int DEC_BITS = COORD_BITS + DEC_EXTRA_BITS;

	logic swap;
	logic dy_pos;
	logic steep;
	logic [COORD_BITS-1:0] ax, ay, bx, by;
	logic [COORD_BITS-1:0] dx, dy_mag;
	logic signed [DEC_BITS-1:0] maj_ext, min_ext;

	// Order the endpoints by x, then sort the line into its slope case.
	always_comb begin
		swap   = x_first > x_second;
		ax     = swap ? x_second : x_first;
		ay     = swap ? y_second : y_first;
		bx     = swap ? x_first  : x_second;
		by     = swap ? y_first  : y_second;
		dx     = bx - ax;
		dy_pos = by > ay;
		dy_mag = dy_pos ? (by - ay) : (ay - by);
		steep  = dy_mag > dx;

		walk_major = ax;
		walk_minor = ay;
		stop_major = bx;
		span_major = dx;
		span_minor = dy_mag;
		if (dy_pos) begin
			if (steep) begin
				slope_case = SLOPE_STEEP_POS;
				walk_major = ay;
				walk_minor = ax;
				stop_major = by;
				span_major = dy_mag;
				span_minor = dx;
			end else begin
				slope_case = SLOPE_SHALLOW_POS;
			end
		end else begin
			if (steep) begin
				// Walked from the lower endpoint so that the major axis rises.
				slope_case = SLOPE_STEEP_NEG;
				walk_major = by;
				walk_minor = bx;
				stop_major = ay;
				span_major = dy_mag;
				span_minor = dx;
			end else begin
				slope_case = SLOPE_SHALLOW_NEG;
			end
		end

		maj_ext = signed'({{(DEC_BITS-COORD_BITS){1'b0}}, span_major});
		min_ext = signed'({{(DEC_BITS-COORD_BITS){1'b0}}, span_minor});
		if (slope_case[1]) begin
			decision = (min_ext <<< 1) - maj_ext;
		end else begin
			decision = maj_ext - (min_ext <<< 1);
		end
	end

endmodule

// ===== src/midpoint_line_rasterizer.sv =====
// An accepted beat is held in the input register; its pixel then goes to the result register.
// Throughput: one beat per cycle, loads and steps alike, unless a pixel stalls; the decision
// update is a single add and compare on registered state, so steps never wait on each other.
// Reset: arst_n clears asynchronously; no line is loaded and both sides come up empty.
// A step beat while no pixels remain is consumed and produces no output beat.
module midpoint_line_rasterizer #(
	parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEFAULT,
	localparam int IN_W  = 8 * ((4 * COORD_BITS + 7) / 8),
	localparam int OUT_W = 8 * ((2 * COORD_BITS + 7) / 8)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// Fields from bit 0 up: x_first, y_first, x_second, y_second, zero fill.
	input  logic [IN_W-1:0]  s_tdata,
	// Field: operation (load or step).
	input  logic             s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// Fields from bit 0 up: pixel_x, pixel_y, zero fill.
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tlast
);
	import mlr_pkg::*;

	localparam int DEC_BITS = COORD_BITS + DEC_EXTRA_BITS;

	// Input register. It holds a beat until the result register can take its pixel.
	logic                  in_valid_s1;
	logic                  in_op_s1;
	logic [4*COORD_BITS-1:0] in_coords_s1;

	// Walker state, kept in the walk frame where the major axis always rises.
	logic [COORD_BITS-1:0]      walk_major_q, walk_minor_q, stop_major_q;
	logic [COORD_BITS-1:0]      span_major_q, span_minor_q;
	logic signed [DEC_BITS-1:0] decision_q;
	slope_t                     slope_case_q;
	logic                       active_q;

	// Result register.
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] pixel_x_q, pixel_y_q;
	logic                  last_q;

	// Load setup results.
	logic [COORD_BITS-1:0]      ld_walk_major, ld_walk_minor, ld_stop_major;
	logic [COORD_BITS-1:0]      ld_span_major, ld_span_minor;
	logic signed [DEC_BITS-1:0] ld_decision;
	slope_t                     ld_slope_case;

	// Next state after the beat held in the input register.
	logic [COORD_BITS-1:0]      nx_walk_major, nx_walk_minor, nx_stop_major;
	logic [COORD_BITS-1:0]      nx_span_major, nx_span_minor;
	logic signed [DEC_BITS-1:0] nx_decision;
	slope_t                     nx_slope_case;
	logic                       nx_active;
	logic                       produce;
	logic                       advance;
	logic signed [DEC_BITS-1:0] maj2, min2;

	// The held beat moves on whenever the result register is empty or is being
	// drained in this cycle; while a stalled pixel blocks it, no new beat can enter.
	assign advance  = in_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !in_valid_s1 || !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_op_s1     <= s_tuser;
			in_coords_s1 <= s_tdata[4*COORD_BITS-1:0];
		end
	end

	mlr_setup #(
		.COORD_BITS(COORD_BITS)
	) u_setup (
		.x_first   (in_coords_s1[COORD_BITS-1:0]),
		.y_first   (in_coords_s1[2*COORD_BITS-1:COORD_BITS]),
		.x_second  (in_coords_s1[3*COORD_BITS-1:2*COORD_BITS]),
		.y_second  (in_coords_s1[4*COORD_BITS-1:3*COORD_BITS]),
		.walk_major(ld_walk_major),
		.walk_minor(ld_walk_minor),
		.stop_major(ld_stop_major),
		.span_major(ld_span_major),
		.span_minor(ld_span_minor),
		.decision  (ld_decision),
		.slope_case(ld_slope_case)
	);

	// A load takes the setup results. A step moves the major axis by one, and the decision
	// term picks whether the minor axis moves too. Falling cases move the minor axis down.
	always_comb begin
		maj2 = signed'({{(DEC_BITS-COORD_BITS){1'b0}}, span_major_q}) <<< 1;
		min2 = signed'({{(DEC_BITS-COORD_BITS){1'b0}}, span_minor_q}) <<< 1;

		nx_walk_major = walk_major_q;
		nx_walk_minor = walk_minor_q;
		nx_stop_major = stop_major_q;
		nx_span_major = span_major_q;
		nx_span_minor = span_minor_q;
		nx_decision   = decision_q;
		nx_slope_case = slope_case_q;
		produce       = 1'b0;

		if (in_op_s1 == OP_LOAD) begin
			nx_walk_major = ld_walk_major;
			nx_walk_minor = ld_walk_minor;
			nx_stop_major = ld_stop_major;
			nx_span_major = ld_span_major;
			nx_span_minor = ld_span_minor;
			nx_decision   = ld_decision;
			nx_slope_case = ld_slope_case;
			produce       = 1'b1;
		end else if (active_q) begin
			nx_walk_major = walk_major_q + COORD_BITS'(1);
			produce       = 1'b1;
			if (!slope_case_q[1]) begin
				if (decision_q > 0) begin
					nx_decision = decision_q - min2;
				end else begin
					nx_walk_minor = walk_minor_q + COORD_BITS'(1);
					nx_decision   = decision_q + maj2 - min2;
				end
			end else begin
				if (decision_q > 0) begin
					nx_walk_minor = walk_minor_q - COORD_BITS'(1);
					nx_decision   = decision_q + min2 - maj2;
				end else begin
					nx_decision = decision_q + min2;
				end
			end
		end
		nx_active = nx_walk_major != nx_stop_major;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_major_q <= '0;
			walk_minor_q <= '0;
			stop_major_q <= '0;
			span_major_q <= '0;
			span_minor_q <= '0;
			decision_q   <= '0;
			slope_case_q <= SLOPE_SHALLOW_POS;
			active_q     <= 1'b0;
		end else if (advance) begin
			walk_major_q <= nx_walk_major;
			walk_minor_q <= nx_walk_minor;
			stop_major_q <= nx_stop_major;
			span_major_q <= nx_span_major;
			span_minor_q <= nx_span_minor;
			decision_q   <= nx_decision;
			slope_case_q <= nx_slope_case;
			active_q     <= nx_active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= produce;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Pixels leave in screen frame: swapped cases trade the axes back.
	always_ff @(posedge clk) begin
		if (advance && produce) begin
			pixel_x_q <= nx_slope_case[0] ? nx_walk_minor : nx_walk_major;
			pixel_y_q <= nx_slope_case[0] ? nx_walk_major : nx_walk_minor;
			last_q    <= !nx_active;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({pixel_y_q, pixel_x_q});
	assign m_tlast  = last_q;

	// A shown pixel is the final one exactly when no further pixels remain.
	a_last_matches_active: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == !active_q))
		else $error("output last flag disagrees with walker state");

	// An active walker has not yet reached its end point.
	a_active_not_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (walk_major_q != stop_major_q))
		else $error("walker active at its end point");

	// Every load yields a pixel.
	a_load_yields_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && in_op_s1 == OP_LOAD) |=> m_tvalid)
		else $error("load produced no pixel");

	// A step with nothing left yields nothing.
	a_idle_step_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && in_op_s1 == OP_STEP && !active_q) |=> !m_tvalid)
		else $error("idle step produced a pixel");

	// A held beat that cannot move on keeps its contents.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !advance) |=> (in_valid_s1 && $stable(in_coords_s1)
			&& $stable(in_op_s1)))
		else $error("stalled input register changed");

endmodule

// ===== sim/mlr_line_checker.sv =====
module mlr_line_checker #(
	parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [8*((4*COORD_BITS+7)/8)-1:0] s_tdata,
	input  logic s_tuser,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [8*((2*COORD_BITS+7)/8)-1:0] m_tdata,
	input  logic m_tlast,
	input  logic closing,
	output int   mismatches,
	output int   pending,
	output int   pixels
);
	import mlr_pkg::*;

	localparam int CB = COORD_BITS;

	typedef logic [CB-1:0] coord_t;
	typedef logic [CB:0] span_t;
	typedef logic signed [15:0] dec_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   last;
	} pixel_t;

	// Walker state, kept in the walk frame where the major axis always rises.
	coord_t             walk_major, walk_minor, stop_major, stop_minor;
	span_t              span_major, span_minor;
	dec_t               decision;
	slope_t             slope;
	logic               line_active;

	pixel_t expected_pixels[$];

	initial begin
		mismatches = 0;
		pending = 0;
		pixels = 0;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < 30)
			$display("[%0t] output beat %0d: %s", $time, pixels, what);
		mismatches++;
	endtask

	task automatic queue_walk_pixel();
		pixel_t px;
		logic   swapped;
		swapped = (slope == SLOPE_STEEP_POS || slope == SLOPE_STEEP_NEG);
		px.x = swapped ? walk_minor : walk_major;
		px.y = swapped ? walk_major : walk_minor;
		px.last = !line_active;
		expected_pixels.push_back(px);
	endtask

	task automatic rasterize_beat(input logic op, input logic [4*CB-1:0] data);
		coord_t ax, ay, bx, by, t;
		int     dx, dy;
		if (op == OP_LOAD) begin
			ax = data[CB-1:0];
			ay = data[2*CB-1:CB];
			bx = data[3*CB-1:2*CB];
			by = data[4*CB-1:3*CB];
			if (ax > bx) begin
				t = ax; ax = bx; bx = t;
				t = ay; ay = by; by = t;
			end
			dx = int'(bx) - int'(ax);
			dy = int'(by) - int'(ay);
			if (dy > 0) begin
				if (dy <= dx) begin
					slope = SLOPE_SHALLOW_POS;
					walk_major = ax; walk_minor = ay; stop_major = bx; stop_minor = by;
					span_major = span_t'(dx); span_minor = span_t'(dy);
				end else begin
					slope = SLOPE_STEEP_POS;
					walk_major = ay; walk_minor = ax; stop_major = by; stop_minor = bx;
					span_major = span_t'(dy); span_minor = span_t'(dx);
				end
				decision = dec_t'(span_major - 2 * span_minor);
			end else begin
				if (-dy <= dx) begin
					slope = SLOPE_SHALLOW_NEG;
					walk_major = ax; walk_minor = ay; stop_major = bx; stop_minor = by;
					span_major = span_t'(dx); span_minor = span_t'(-dy);
				end else begin
					// Steep falling lines are walked from the lower endpoint upward.
					slope = SLOPE_STEEP_NEG;
					walk_major = by; walk_minor = bx; stop_major = ay; stop_minor = ax;
					span_major = span_t'(-dy); span_minor = span_t'(dx);
				end
				decision = dec_t'(2 * span_minor - span_major);
			end
			line_active = (walk_major != stop_major);
			queue_walk_pixel();
		end else if (line_active) begin
			walk_major = walk_major + 1'b1;
			if (slope == SLOPE_SHALLOW_POS || slope == SLOPE_STEEP_POS) begin
				if (decision > 0) begin
					decision = dec_t'(decision - 2 * span_minor);
				end else begin
					walk_minor = walk_minor + 1'b1;
					decision = dec_t'(decision + 2 * span_major - 2 * span_minor);
				end
			end else begin
				if (decision > 0) begin
					walk_minor = walk_minor - 1'b1;
					decision = dec_t'(decision + 2 * span_minor - 2 * span_major);
				end else begin
					decision = dec_t'(decision + 2 * span_minor);
				end
			end
			line_active = (walk_major != stop_major);
			queue_walk_pixel();
		end
	endtask

	task automatic compare_pixel();
		pixel_t want;
		if (expected_pixels.size() == 0) begin
			report_mismatch("pixel arrived with nothing expected");
		end else begin
			want = expected_pixels.pop_front();
			if (m_tdata[CB-1:0] !== want.x)
				report_mismatch($sformatf("pixel_x %0d, expected %0d", m_tdata[CB-1:0], want.x));
			if (m_tdata[2*CB-1:CB] !== want.y)
				report_mismatch($sformatf("pixel_y %0d, expected %0d",
					m_tdata[2*CB-1:CB], want.y));
			if (m_tlast !== want.last)
				report_mismatch($sformatf("last %0b, expected %0b", m_tlast, want.last));
		end
		pixels++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			walk_major = '0;
			walk_minor = '0;
			stop_major = '0;
			stop_minor = '0;
			span_major = '0;
			span_minor = '0;
			decision = '0;
			slope = SLOPE_SHALLOW_POS;
			line_active = 1'b0;
			expected_pixels.delete();
		end else begin
			if (s_tvalid && s_tready)
				rasterize_beat(s_tuser, s_tdata[4*CB-1:0]);
			if (m_tvalid && m_tready)
				compare_pixel();
		end
		pending = expected_pixels.size();
	end

	always @(posedge closing) begin
		if (expected_pixels.size() != 0)
			report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));
	end

endmodule

// ===== sim/tb_midpoint_line_rasterizer.sv =====
module tb_midpoint_line_rasterizer;
	import mlr_pkg::*;

	localparam int CB = COORD_BITS_DEFAULT;
	localparam int IN_W = 8 * ((4 * CB + 7) / 8);
	localparam int OUT_W = 8 * ((2 * CB + 7) / 8);

	// Random stimulus runs until about this many useful beats have been accepted.
	localparam int WORK_BEATS = 2000;
	// The receiver's long hold-off, and the window where neither side idles.
	localparam int HOLD_CYCLES = 250;
	localparam int QUIET_FROM = 600;
	localparam int QUIET_TO = 900;
	localparam int HOLD_AT = 1200;
	// The pixel pipeline is an input register and a result register, so a short tail is plenty.
	localparam int TAIL_CYCLES = 8;
	// Longest legal silence is the receiver hold plus a few idle gaps.
	localparam int STALL_LIMIT = 3000;

	typedef logic [CB-1:0] coord_t;
	localparam coord_t CMAX = '1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tuser = OP_LOAD;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tready = 1'b0;
	logic              closing = 1'b0;
	wire               s_tready;
	wire               m_tvalid;
	wire  [OUT_W-1:0]  m_tdata;
	wire               m_tlast;

	int mismatches;
	int pending;
	int pixels;

	// quiet and hold_req are shared between the sender and the receiver process; hold_left is the receiver's.
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	int beats_sent = 0;
	int lines_sent = 0;
	int work_beats = 0;
	int stalled = 0;

	midpoint_line_rasterizer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	mlr_line_checker #(.COORD_BITS(CB)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.closing    (closing),
		.mismatches (mismatches),
		.pending    (pending),
		.pixels     (pixels)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offers one beat, with an occasional idle gap in front of it, and returns once
	// the beat has been accepted. The input fields are packed x_first at bit 0 up to
	// y_second at the top.
	task automatic offer(input logic op, input coord_t ax, input coord_t ay,
		input coord_t bx, input coord_t by);
		while (!quiet && $urandom_range(99) < 9) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {by, bx, ay, ax};
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	// Step beats carry random coordinates, which the block must ignore.
	task automatic offer_step();
		offer(OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom));
	endtask

	task automatic draw_line(input coord_t ax, input coord_t ay, input coord_t bx,
		input coord_t by, input int steps);
		offer(OP_LOAD, ax, ay, bx, by);
		lines_sent++;
		repeat (steps) offer_step();
	endtask

	// Pixels after the first one: the larger of the two extents.
	function automatic int line_span(coord_t ax, coord_t ay, coord_t bx, coord_t by);
		int dx, dy;
		dx = int'(bx) - int'(ax);
		dy = int'(by) - int'(ay);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		return (dx > dy) ? dx : dy;
	endfunction

	// Screen edges turn up often so that lines along the frame's border get exercised.
	function automatic coord_t pick_coord();
		if ($urandom_range(99) < 12)
			return $urandom_range(1) ? CMAX : coord_t'(0);
		return coord_t'($urandom_range(CMAX));
	endfunction

	// Second endpoint near the first; a quarter of the time the axis stays put,
	// which gives horizontal, vertical and single point lines.
	function automatic coord_t nudge(coord_t c);
		int v;
		if ($urandom_range(3) == 0)
			return c;
		v = int'(c) + $urandom_range(48) - 24;
		if (v < 0) v = 0;
		if (v > int'(CMAX)) v = CMAX;
		return coord_t'(v);
	endfunction

	// Receiver: random stalls, none in the quiet window, and one long hold-off.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet || ($urandom_range(99) >= 9);
			end
		end
	end

	// Watchdog: ends the run if neither channel moves for too long.
	initial begin
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stalled = 0;
			else
				stalled++;
		end
		$display("No beat moved for %0d cycles, giving up.", STALL_LIMIT);
		$display("midpoint_line_rasterizer: mismatch");
		$finish;
	end

	initial begin
		int     span, steps, roll;
		bit     hold_done;
		coord_t ax, ay, bx, by;
		hold_done = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines. A step before any load must be swallowed silently.
		offer_step();
		// Single point at the far corner, then a stray step past its end.
		draw_line(CMAX, CMAX, CMAX, CMAX, 1);
		// Full-frame diagonal, abandoned early by the next load.
		draw_line(0, 0, CMAX, CMAX, 2);
		// Shallow rising line ending on the corner.
		draw_line(coord_t'(CMAX - 3), coord_t'(CMAX - 1), CMAX, CMAX, 3);
		// Steep rising line.
		draw_line(1, 0, 2, 3, 3);
		// Steep falling line, walked from its lower end, plus a step past the end.
		draw_line(5, 0, 4, 3, 4);
		// Horizontal and vertical lines take the falling cases.
		draw_line(0, 7, 2, 7, 2);
		draw_line(9, CMAX, 9, coord_t'(CMAX - 2), 2);
		// Shallow falling line reaching row zero.
		draw_line(0, 2, 3, 0, 3);

		// Let everything drain before the random part starts.
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);

		while (work_beats < WORK_BEATS) begin
			quiet = (work_beats >= QUIET_FROM && work_beats < QUIET_TO);
			if (!hold_done && work_beats >= HOLD_AT) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			roll = $urandom_range(99);
			if (roll < 4) begin
				// Stray step: usually lands after a line has ended.
				offer_step();
			end else begin
				ax = pick_coord();
				ay = pick_coord();
				if (roll < 8) begin
					bx = pick_coord();
					by = pick_coord();
				end else begin
					bx = nudge(ax);
					by = nudge(ay);
				end
				span = line_span(ax, ay, bx, by);
				roll = $urandom_range(99);
				// Long lines are only walked part way before a new load cuts in.
				if (span > 48)
					steps = $urandom_range(48);
				else if (roll < 10)
					steps = span + $urandom_range(1, 3);
				else if (roll < 20)
					steps = $urandom_range(span);
				else
					steps = span;
				draw_line(ax, ay, bx, by, steps);
				work_beats += 1 + ((steps < span) ? steps : span);
			end
		end
		quiet = 1'b0;
		s_tvalid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		closing = 1'b1;
		@(posedge clk);

		$display("Drew %0d lines over %0d input beats and checked %0d pixels,",
			lines_sent, beats_sent, pixels);
		$display("with random stalls on both sides, one long output hold and one full drain.");
		if (mismatches == 0)
			$display("midpoint_line_rasterizer: match");
		else
			$display("midpoint_line_rasterizer: mismatch");
		$finish;
	end

endmodule
